FILE: rtl/assert_macros.svh
// Assertion macros for the stroke line rasteriser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SLR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define SLR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define SLR_ASSERT(lbl, prop, msg)
`define SLR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/slr_pkg.sv
package slr_pkg;

    localparam int COORD_BITS_DEF = 13;
    localparam int MAX_POINTS_DEF = 64;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [1:0] OP_PRESS   = 2'd0;
    localparam logic [1:0] OP_MOVE    = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

FILE: rtl/slr_queue.sv
`include "assert_macros.svh"

module slr_queue #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  logic [WIDTH-1:0]      push_data,
    input  logic                  pop,
    output logic [WIDTH-1:0]      head_data,
    output slr_pkg::q_status_t    status
);
    import slr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign status.full  = (cnt_reg == CW'(DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign head_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `SLR_ASSERT(a_cnt_bound, cnt_reg <= CW'(DEPTH), "queue count beyond depth")
    `SLR_ASSERT(a_push_full, status.full |-> !do_push, "push into full queue")
    `SLR_ASSERT(a_ptr_match, status.empty |-> (wr_ptr_reg == rd_ptr_reg), "empty queue pointers differ")

endmodule

FILE: rtl/slr_front.sv
module slr_front #(
    parameter int COORD_BITS = 13
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_opcode,
    input  logic                    s_left_button,
    input  logic signed [COORD_BITS-1:0] s_pen_x,
    input  logic signed [COORD_BITS-1:0] s_pen_y,
    input  slr_pkg::q_status_t      q_status,
    output logic                    q_push,
    output logic [4*COORD_BITS-1:0] q_data
);
    import slr_pkg::*;

    logic                  drawing_reg, drawing_next;
    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic                  accept;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign q_data  = {cur_x_reg, cur_y_reg, s_pen_x, s_pen_y};

    always_comb begin
        drawing_next = drawing_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        q_push       = 1'b0;
        if (accept) begin
            case (s_opcode)
                OP_PRESS: begin
                    if (s_left_button) begin
                        drawing_next = 1'b1;
                        cur_x_next   = s_pen_x;
                        cur_y_next   = s_pen_y;
                    end
                end
                OP_MOVE, OP_RELEASE: begin
                    if (s_left_button && drawing_reg) begin
                        q_push     = 1'b1;
                        cur_x_next = s_pen_x;
                        cur_y_next = s_pen_y;
                        if (s_opcode == OP_RELEASE) begin
                            drawing_next = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drawing_reg <= 1'b0;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
        end else begin
            drawing_reg <= drawing_next;
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
        end
    end

endmodule

FILE: rtl/slr_back.sv
`include "assert_macros.svh"

module slr_back #(
    parameter int COORD_BITS = 13,
    parameter int MAX_POINTS = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  slr_pkg::q_status_t      q_status,
    input  logic [4*COORD_BITS-1:0] q_data,
    output logic                    q_pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [COORD_BITS-1:0] m_pixel_x,
    output logic signed [COORD_BITS-1:0] m_pixel_y,
    output logic                    m_last_point,
    output logic                    m_clipped
);
    import slr_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int WD = COORD_BITS + 2;
    localparam int NW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SETUP = 3'b010,
        ST_RUN   = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CB-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic signed [WD-1:0] sx0, sy0, sx1, sy1, dx, dy, adx, ady;
    logic signed [WD-1:0] t_reg, qf_reg, rf_reg, den_reg, step_reg, base_reg;
    logic [NW-1:0] cnt_reg;
    logic          xmaj_reg, zero_reg, clip_reg;
    logic          xmaj;
    logic signed [WD-1:0] tot;
    logic signed [WD-1:0] rf_sum, minor;
    logic          out_free, emit;
    logic          valid_reg;
    logic [CB-1:0] px_reg, py_reg;
    logic          last_reg, clipo_reg;

    assign sx0 = {{2{x0_reg[CB-1]}}, x0_reg};
    assign sy0 = {{2{y0_reg[CB-1]}}, y0_reg};
    assign sx1 = {{2{x1_reg[CB-1]}}, x1_reg};
    assign sy1 = {{2{y1_reg[CB-1]}}, y1_reg};
    assign dx  = sx1 - sx0;
    assign dy  = sy1 - sy0;
    assign adx = dx[WD-1] ? -dx : dx;
    assign ady = dy[WD-1] ? -dy : dy;
    assign xmaj = adx > ady;
    assign tot = (xmaj ? adx : ady) + WD'(1);

    assign out_free = !valid_reg || m_ready;
    assign emit     = (state_reg == ST_RUN) && out_free;
    assign q_pop    = (state_reg == ST_IDLE) && !q_status.empty;
    assign rf_sum   = rf_reg + step_reg;

    // minor coordinate: truncation for x-major, half-away rounding for y-major
    always_comb begin
        if (xmaj_reg) begin
            minor = base_reg + qf_reg
                  + ((qf_reg[WD-1] && (rf_reg != '0)) ? WD'(1) : WD'(0));
        end else if (zero_reg) begin
            minor = base_reg;
        end else if ((rf_reg <<< 1) > den_reg) begin
            minor = qf_reg + WD'(1);
        end else if (((rf_reg <<< 1) == den_reg) && !qf_reg[WD-1]) begin
            minor = qf_reg + WD'(1);
        end else begin
            minor = qf_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (!q_status.empty) state_next = ST_SETUP;
            ST_SETUP: state_next = ST_RUN;
            ST_RUN:   if (emit && (cnt_reg == '0)) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            {x0_reg, y0_reg, x1_reg, y1_reg} <= q_data;
        end
        if (state_reg == ST_SETUP) begin
            xmaj_reg <= xmaj;
            zero_reg <= (dy == '0);
            rf_reg   <= '0;
            clip_reg <= tot > WD'(MAX_POINTS);
            cnt_reg  <= (tot > WD'(MAX_POINTS)) ? NW'(MAX_POINTS - 1) : NW'(tot - WD'(1));
            if (xmaj) begin
                den_reg  <= adx;
                step_reg <= dx[WD-1] ? -dy : dy;
                qf_reg   <= dx[WD-1] ? dy : '0;
                t_reg    <= dx[WD-1] ? sx1 : sx0;
                base_reg <= sy0;
            end else begin
                den_reg  <= ady;
                step_reg <= dy[WD-1] ? -dx : dx;
                qf_reg   <= dy[WD-1] ? sx1 : sx0;
                t_reg    <= dy[WD-1] ? sy1 : sy0;
                base_reg <= sx0;
            end
        end else if (emit) begin
            px_reg    <= xmaj_reg ? t_reg[CB-1:0] : minor[CB-1:0];
            py_reg    <= xmaj_reg ? minor[CB-1:0] : t_reg[CB-1:0];
            last_reg  <= (cnt_reg == '0);
            clipo_reg <= (cnt_reg == '0) && clip_reg;
            t_reg     <= t_reg + WD'(1);
            cnt_reg   <= cnt_reg - 1'b1;
            if (rf_sum >= den_reg) begin
                rf_reg <= rf_sum - den_reg;
                qf_reg <= qf_reg + WD'(1);
            end else if (rf_sum[WD-1]) begin
                rf_reg <= rf_sum + den_reg;
                qf_reg <= qf_reg - WD'(1);
            end else begin
                rf_reg <= rf_sum;
            end
        end
    end

    assign m_valid      = valid_reg;
    assign m_pixel_x    = px_reg;
    assign m_pixel_y    = py_reg;
    assign m_last_point = last_reg;
    assign m_clipped    = clipo_reg;

    `SLR_ASSERT(a_clip_last, (valid_reg && clipo_reg) |-> last_reg, "clipped without last point")
    `SLR_ASSERT(a_emit_run, emit |-> (state_reg == ST_RUN), "word emitted outside run")
    `SLR_ASSERT(a_pop_idle, q_pop |=> (state_reg == ST_SETUP), "pop not followed by setup")

endmodule

FILE: rtl/stroke_line_rasterizer.sv
// Stroke line rasteriser.
// Input channel s_*: one pen event per word (opcode, left_button, pen_x, pen_y).
// A left press stores the point; a left move or release while drawing turns the
// segment from the stored point to the new one into pixel words on m_*, one
// point per word, last_point marking the final one and clipped flagging a
// segment cut at MAX_POINTS points.
// Events are classified at once and a segment lands in a small queue, so the
// input keeps taking words while the back end still draws a previous segment.
// After an event is taken, its segment passes through the queue, the idle pop
// and the setup state before the run state registers the first pixel word; then
// one pixel per cycle unless a pending word is held by a low m_ready, with the
// minor coordinate tracked by an incremental quotient and remainder. Events that
// draw nothing never enter the queue. s_ready drops only when the queue is full.
// When m_ready is low while a word is pending, the output word holds and stepping pauses.
// Reset (aresetn low, synchronous): not drawing, pen point (0,0), queue empty,
// no output word pending.
module stroke_line_rasterizer #(
    parameter int COORD_BITS  = slr_pkg::COORD_BITS_DEF,
    parameter int MAX_POINTS  = slr_pkg::MAX_POINTS_DEF,
    parameter int QUEUE_DEPTH = slr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_opcode,
    input  logic                         s_left_button,
    input  logic signed [COORD_BITS-1:0] s_pen_x,
    input  logic signed [COORD_BITS-1:0] s_pen_y,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COORD_BITS-1:0] m_pixel_x,
    output logic signed [COORD_BITS-1:0] m_pixel_y,
    output logic                         m_last_point,
    output logic                         m_clipped
);
    import slr_pkg::*;

    q_status_t               q_status;
    logic                    q_push, q_pop;
    logic [4*COORD_BITS-1:0] q_in, q_head;

    slr_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_opcode, .s_left_button,
        .s_pen_x, .s_pen_y, .q_status, .q_push, .q_data(q_in)
    );

    slr_queue #(.WIDTH(4*COORD_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk, .aresetn, .push(q_push), .push_data(q_in), .pop(q_pop),
        .head_data(q_head), .status(q_status)
    );

    slr_back #(.COORD_BITS(COORD_BITS), .MAX_POINTS(MAX_POINTS)) u_back (
        .aclk, .aresetn, .q_status, .q_data(q_head), .q_pop,
        .m_valid, .m_ready, .m_pixel_x, .m_pixel_y, .m_last_point, .m_clipped
    );

endmodule
